[hdl/tws_pkg.sv]
// shared constants, register indexes and angle table for the three-wheel swerve kinematics block
package tws_pkg;

   localparam int TIMEOUT_TICKS_DEF = 50;
   localparam int CORDIC_STEPS_DEF  = 16;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int WHEEL_W    = 2;
   localparam int STEER_W    = 17;
   localparam int RPM_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_FRONT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_BLEFT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_BRIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_SIGNS = 3'd7;

   localparam logic                OP_COMMAND = 1'b0;
   localparam logic                OP_TICK    = 1'b1;
   localparam logic [WHEEL_W-1:0]  WHEEL_FRONT  = 2'd0;
   localparam logic [WHEEL_W-1:0]  WHEEL_BRIGHT = 2'd2;

   localparam logic [11:0] RADIUS_RST      = 12'd250;
   localparam logic [14:0] SPEED_LIMIT_RST = 15'd3000;
   localparam logic [14:0] TURN_LIMIT_RST  = 15'd3000;
   localparam logic [19:0] DRIVE_GAIN_RST  = 20'd79272;

   localparam logic [63:0] SQRT3_HALF_Q16 = 64'd56756;
   localparam logic [63:0] MM_TO_UM       = 64'd1000;
   localparam logic [63:0] RPM_ROUND      = 64'd32768000;
   localparam logic [63:0] RPM_T_SAT      = 64'd3501000;
   // ceil(2^32 / 1000), exact for the saturated range
   localparam logic [63:0] RPM_RECIP      = 64'd4294968;
   localparam logic [63:0] RPM_LIMIT      = 64'd3500;
   localparam logic signed [15:0] DEADBAND = 16'sd10;
   localparam logic signed [63:0] QUARTER_TURN = 64'sd2304000;

   function automatic logic [23:0] atan_entry(input logic [4:0] idx);
      logic [23:0] v;
      unique case (idx)
         5'd0:  v = 24'd1152000;
         5'd1:  v = 24'd680065;
         5'd2:  v = 24'd359328;
         5'd3:  v = 24'd182400;
         5'd4:  v = 24'd91554;
         5'd5:  v = 24'd45822;
         5'd6:  v = 24'd22916;
         5'd7:  v = 24'd11459;
         5'd8:  v = 24'd5730;
         5'd9:  v = 24'd2865;
         5'd10: v = 24'd1432;
         5'd11: v = 24'd716;
         5'd12: v = 24'd358;
         5'd13: v = 24'd179;
         5'd14: v = 24'd90;
         5'd15: v = 24'd45;
         5'd16: v = 24'd22;
         5'd17: v = 24'd11;
         5'd18: v = 24'd6;
         5'd19: v = 24'd3;
         5'd20: v = 24'd1;
         5'd21: v = 24'd1;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

endpackage

[hdl/three_wheel_swerve_kinematics.sv]
// three-wheel swerve inverse kinematics: command limiting, timeout and per-wheel targets
//
// req channel: op in tuser (0 velocity command, 1 control tick), lin_x, lin_y and
// turn_rate in tdata. a command is limited and held and gives no result. a tick ages
// the held command and gives three rsp transactions (front, back-left, back-right),
// tlast on the third.
// csr channel: always ready, register index and data, to be written while the block is
// idle (the block itself does not enforce this). one shift-add multiplier / restoring
// divider / square root / cordic engine is stepped by a sequencer, one bit or one
// rotation per cycle.
// a command's speed is scaled down when it exceeds the speed limit. a tick outside the
// deadband works out each wheel's vector, and the wheel speeds are scaled down when one
// exceeds the limit.
// req_tready is high only while idle; one item is worked on at a time.
// each result sits in the output register until taken; a stalled receiver holds
// the sequencer, nothing is lost.
// reset (synchronous) restores register defaults, clears the held command and the
// idle counter and drops any pending result.
module three_wheel_swerve_kinematics #(
   parameter int TIMEOUT_TICKS = tws_pkg::TIMEOUT_TICKS_DEF,
   parameter int CORDIC_STEPS  = tws_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tws_pkg::REQ_DATA_W-1:0]    req_tdata,  // lin_x, lin_y, turn_rate
   input  logic                              req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tws_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // steer_target, drive_rpm, zero pad
   output logic [tws_pkg::WHEEL_W-1:0]       rsp_tuser,  // wheel
   output logic                              rsp_tlast,  // last_wheel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tws_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tws_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ENG,
      ST_CMD_SQY, ST_CMD_LSQ, ST_CMD_CMP, ST_CMD_ROOT, ST_CMD_DIV, ST_CMD_QUO, ST_CMD_FIN,
      ST_TK_DB, ST_TK_A, ST_TK_B, ST_TK_BX, ST_TK_BY, ST_TK_SQY, ST_TK_ROOT, ST_TK_ANG,
      ST_TK_HEAD, ST_TK_SMUL, ST_TK_SDIV, ST_TK_SQUO,
      ST_RP_MUL, ST_RP_DIV, ST_RP_OUT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {EOP_MUL, EOP_DIV, EOP_SQRT, EOP_CORDIC} eng_op_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   eng_op_type  eng_op_ff, eng_op_in;
   logic [6:0]  eng_cnt_ff, eng_cnt_in;
   logic [63:0] eng_a_ff, eng_a_in, eng_b_ff, eng_b_in, eng_c_ff, eng_c_in;

   logic [11:0]        radius_ff, radius_in;
   logic [14:0]        slim_ff, slim_in, tlim_ff, tlim_in;
   logic [19:0]        gain_ff, gain_in;
   logic signed [15:0] off_ff [3];
   logic signed [15:0] off_in [3];
   logic [2:0]         signs_ff, signs_in;

   logic signed [15:0] hvx_ff, hvx_in, hvy_ff, hvy_in, htn_ff, htn_in;
   logic [15:0]        idle_ff, idle_in;

   logic signed [15:0] cv_ff [2];
   logic signed [15:0] cv_in [2];
   logic signed [15:0] cwz_ff, cwz_in;
   logic               k_ff, k_in;
   logic [63:0]        tmp_ff, tmp_in;
   logic [28:0]        den_ff, den_in;
   logic signed [28:0] ta_ff, ta_in, tb_ff, tb_in, thf_ff, thf_in;
   logic signed [25:0] tbx_ff, tbx_in;
   logic signed [29:0] cx_ff [3];
   logic signed [29:0] cx_in [3];
   logic signed [29:0] cy_ff [3];
   logic signed [29:0] cy_in [3];
   logic [28:0]        spd_ff [3];
   logic [28:0]        spd_in [3];
   logic signed [15:0] head_ff [3];
   logic signed [15:0] head_in [3];
   logic [1:0]         w_ff, w_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_wheel_ff, rsp_wheel_in;
   logic signed [16:0] rsp_steer_ff, rsp_steer_in;
   logic signed [12:0] rsp_rpm_ff, rsp_rpm_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               go;
   eng_op_type         go_op;
   logic [63:0]        go_x, go_y;
   state_type          go_ret;
   logic [63:0]        rem, sq_bit, sq_try, rp_t;
   logic [4:0]         sq_k, cd_i;
   logic signed [63:0] cd_x, cd_y, cd_dx, cd_dy, p_mul, hz;
   logic [15:0]        idle_sat;
   logic [24:0]        lim1000;
   logic signed [25:0] by_v;
   logic [1:0]         wn;
   logic [12:0]        rpm_v;
   logic signed [16:0] wz_x, tl_x;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_rpm_ff, rsp_steer_ff};
   assign rsp_tuser  = rsp_wheel_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign lim1000  = 25'(slim_ff) * 25'd1000;
   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign wn       = w_ff + 2'd1;
   assign wz_x     = 17'(cwz_ff);
   assign tl_x     = 17'(tlim_ff);

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;
      eng_op_in = eng_op_ff;  eng_cnt_in = eng_cnt_ff;
      eng_a_in = eng_a_ff;  eng_b_in = eng_b_ff;  eng_c_in = eng_c_ff;
      radius_in = radius_ff;  slim_in = slim_ff;  tlim_in = tlim_ff;  gain_in = gain_ff;
      off_in = off_ff;  signs_in = signs_ff;
      hvx_in = hvx_ff;  hvy_in = hvy_ff;  htn_in = htn_ff;  idle_in = idle_ff;
      cv_in = cv_ff;  cwz_in = cwz_ff;  k_in = k_ff;  tmp_in = tmp_ff;  den_in = den_ff;
      ta_in = ta_ff;  tb_in = tb_ff;  thf_in = thf_ff;  tbx_in = tbx_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  spd_in = spd_ff;  head_in = head_ff;  w_in = w_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_wheel_in = rsp_wheel_ff;
      rsp_steer_in = rsp_steer_ff;  rsp_rpm_in = rsp_rpm_ff;  rsp_last_in = rsp_last_ff;
      go = 1'b0;  go_op = EOP_MUL;  go_x = '0;  go_y = '0;  go_ret = ST_IDLE;
      rem = '0;  sq_bit = '0;  sq_try = '0;  rp_t = '0;  sq_k = '0;  cd_i = '0;
      cd_x = '0;  cd_y = '0;  cd_dx = '0;  cd_dy = '0;  p_mul = '0;  hz = '0;
      by_v = '0;  rpm_v = '0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_RADIUS:      radius_in = csr_data[11:0];
            REG_SPEED_LIMIT: slim_in = csr_data[14:0];
            REG_TURN_LIMIT:  tlim_in = csr_data[14:0];
            REG_DRIVE_GAIN:  gain_in = csr_data;
            REG_OFF_FRONT:   off_in[0] = $signed(csr_data[15:0]);
            REG_OFF_BLEFT:   off_in[1] = $signed(csr_data[15:0]);
            REG_OFF_BRIGHT:  off_in[2] = $signed(csr_data[15:0]);
            REG_DRIVE_SIGNS: signs_in = csr_data[2:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_COMMAND) begin
                  cv_in[0] = $signed(req_tdata[15:0]);
                  cv_in[1] = $signed(req_tdata[31:16]);
                  cwz_in   = $signed(req_tdata[47:32]);
                  go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_CMD_SQY;
                  go_x = mag64(64'($signed(req_tdata[15:0])));
                  go_y = go_x;
               end else begin
                  idle_in = idle_sat;
                  if ({1'b0, idle_sat} > 17'(TIMEOUT_TICKS)) begin
                     hvx_in = '0;  hvy_in = '0;  htn_in = '0;
                  end
                  state_in = ST_TK_DB;
               end
            end
         end
         ST_ENG: begin
            if (eng_cnt_ff == '0) begin
               state_in = ret_ff;
            end else begin
               eng_cnt_in = eng_cnt_ff - 7'd1;
               unique case (eng_op_ff)
                  EOP_MUL: begin
                     if (eng_b_ff[0]) eng_c_in = eng_c_ff + eng_a_ff;
                     eng_a_in = eng_a_ff << 1;
                     eng_b_in = eng_b_ff >> 1;
                  end
                  EOP_DIV: begin
                     rem = {eng_a_ff[62:0], eng_b_ff[63]};
                     eng_b_in = {eng_b_ff[62:0], 1'b0};
                     if (rem >= eng_c_ff) begin
                        eng_a_in    = rem - eng_c_ff;
                        eng_b_in[0] = 1'b1;
                     end else begin
                        eng_a_in = rem;
                     end
                  end
                  EOP_SQRT: begin
                     sq_k   = 5'(eng_cnt_ff - 7'd1);
                     sq_bit = 64'd1 << {sq_k, 1'b0};
                     sq_try = eng_b_ff + sq_bit;
                     if (eng_a_ff >= sq_try) begin
                        eng_a_in = eng_a_ff - sq_try;
                        eng_b_in = (eng_b_ff >> 1) + sq_bit;
                     end else begin
                        eng_b_in = eng_b_ff >> 1;
                     end
                  end
                  EOP_CORDIC: begin
                     cd_i  = 5'(7'(CORDIC_STEPS) - eng_cnt_ff);
                     cd_x  = $signed(eng_a_ff);
                     cd_y  = $signed(eng_b_ff);
                     cd_dx = cd_y >>> cd_i;
                     cd_dy = cd_x >>> cd_i;
                     if (cd_y > 0) begin
                        eng_a_in = 64'(cd_x + cd_dx);
                        eng_b_in = 64'(cd_y - cd_dy);
                        eng_c_in = eng_c_ff + 64'(atan_entry(cd_i));
                     end else begin
                        eng_a_in = 64'(cd_x - cd_dx);
                        eng_b_in = 64'(cd_y + cd_dy);
                        eng_c_in = eng_c_ff - 64'(atan_entry(cd_i));
                     end
                  end
               endcase
            end
         end
         ST_CMD_SQY: begin
            tmp_in = eng_c_ff;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_CMD_LSQ;
            go_x = mag64(64'(cv_ff[1]));  go_y = go_x;
         end
         ST_CMD_LSQ: begin
            tmp_in = tmp_ff + eng_c_ff;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_CMD_CMP;
            go_x = 64'(slim_ff);  go_y = go_x;
         end
         ST_CMD_CMP: begin
            if (tmp_ff > eng_c_ff) begin
               go = 1'b1;  go_op = EOP_SQRT;  go_ret = ST_CMD_ROOT;  go_x = tmp_ff;
            end else begin
               state_in = ST_CMD_FIN;
            end
         end
         ST_CMD_ROOT: begin
            den_in = eng_b_ff[28:0];
            k_in   = 1'b0;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_CMD_DIV;
            go_x = mag64(64'(cv_ff[0]));  go_y = 64'(slim_ff);
         end
         ST_CMD_DIV: begin
            go = 1'b1;  go_op = EOP_DIV;  go_ret = ST_CMD_QUO;
            go_x = eng_c_ff + 64'(den_ff >> 1);  go_y = 64'(den_ff);
         end
         ST_CMD_QUO: begin
            cv_in[k_ff] = cv_ff[k_ff][15] ? -$signed(eng_b_ff[15:0]) : $signed(eng_b_ff[15:0]);
            if (!k_ff) begin
               k_in = 1'b1;
               go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_CMD_DIV;
               go_x = mag64(64'(cv_ff[1]));  go_y = 64'(slim_ff);
            end else begin
               state_in = ST_CMD_FIN;
            end
         end
         ST_CMD_FIN: begin
            hvx_in = cv_ff[0];
            hvy_in = cv_ff[1];
            priority if (wz_x > tl_x) htn_in = 16'(tl_x);
            else if (wz_x < -tl_x)    htn_in = 16'(-tl_x);
            else                      htn_in = cwz_ff;
            idle_in  = '0;
            state_in = ST_IDLE;
         end
         ST_TK_DB: begin
            w_in = '0;
            if (hvx_ff > DEADBAND || hvx_ff < -DEADBAND || hvy_ff > DEADBAND ||
                hvy_ff < -DEADBAND || htn_ff > DEADBAND || htn_ff < -DEADBAND) begin
               go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_A;
               go_x = mag64(64'(htn_ff));  go_y = 64'(radius_ff);
            end else begin
               for (int i = 0; i < 3; i++) begin
                  spd_in[i]  = '0;
                  head_in[i] = '0;
               end
               state_in = ST_RP_MUL;
            end
         end
         ST_TK_A: begin
            ta_in = htn_ff[15] ? -$signed(29'(eng_c_ff)) : $signed(29'(eng_c_ff));
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_B;
            go_x = eng_c_ff;  go_y = SQRT3_HALF_Q16;
         end
         ST_TK_B: begin
            p_mul  = htn_ff[15] ? -$signed(eng_c_ff) : $signed(eng_c_ff);
            tb_in  = 29'((p_mul + 64'sd32768) >>> 16);
            thf_in = 29'((30'(ta_ff) + 30'sd1) >>> 1);
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_BX;
            go_x = mag64(64'(hvx_ff));  go_y = MM_TO_UM;
         end
         ST_TK_BX: begin
            tbx_in = hvx_ff[15] ? -$signed(26'(eng_c_ff)) : $signed(26'(eng_c_ff));
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_BY;
            go_x = mag64(64'(hvy_ff));  go_y = MM_TO_UM;
         end
         ST_TK_BY: begin
            by_v = hvy_ff[15] ? -$signed(26'(eng_c_ff)) : $signed(26'(eng_c_ff));
            cx_in[0] = 30'(tbx_ff);
            cx_in[1] = 30'(tbx_ff) - 30'(tb_ff);
            cx_in[2] = 30'(tbx_ff) + 30'(tb_ff);
            cy_in[0] = 30'(by_v) + 30'(ta_ff);
            cy_in[1] = 30'(by_v) - 30'(thf_ff);
            cy_in[2] = 30'(by_v) - 30'(thf_ff);
            den_in = '0;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_SQY;
            go_x = mag64(64'(tbx_ff));  go_y = go_x;
         end
         ST_TK_SQY: begin
            tmp_in = eng_c_ff;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_ROOT;
            go_x = mag64(64'(cy_ff[w_ff]));  go_y = go_x;
         end
         ST_TK_ROOT: begin
            go = 1'b1;  go_op = EOP_SQRT;  go_ret = ST_TK_ANG;
            go_x = tmp_ff + eng_c_ff;
         end
         ST_TK_ANG: begin
            spd_in[w_ff] = eng_b_ff[28:0];
            if (eng_b_ff[28:0] > den_ff) den_in = eng_b_ff[28:0];
            go = 1'b1;  go_op = EOP_CORDIC;  go_ret = ST_TK_HEAD;
            go_x = 64'(cx_ff[w_ff]);  go_y = 64'(cy_ff[w_ff]);
         end
         ST_TK_HEAD: begin
            hz = ($signed(eng_c_ff) + 64'sd128) >>> 8;
            priority if (hz > 64'sd18000)   hz = hz - 64'sd36000;
            else if (hz <= -64'sd18000)     hz = hz + 64'sd36000;
            else                            hz = hz;
            head_in[w_ff] = (cx_ff[w_ff] == '0 && cy_ff[w_ff] == '0) ? '0 : 16'(hz);
            if (w_ff != WHEEL_BRIGHT) begin
               w_in = wn;
               go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_SQY;
               go_x = mag64(64'(cx_ff[wn]));  go_y = go_x;
            end else begin
               w_in = '0;
               state_in = (den_ff > 29'(lim1000)) ? ST_TK_SMUL : ST_RP_MUL;
            end
         end
         ST_TK_SMUL: begin
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_TK_SDIV;
            go_x = 64'(spd_ff[w_ff]);  go_y = 64'(lim1000);
         end
         ST_TK_SDIV: begin
            go = 1'b1;  go_op = EOP_DIV;  go_ret = ST_TK_SQUO;
            go_x = eng_c_ff + 64'(den_ff >> 1);  go_y = 64'(den_ff);
         end
         ST_TK_SQUO: begin
            spd_in[w_ff] = eng_b_ff[28:0];
            if (w_ff == WHEEL_BRIGHT) begin
               w_in = '0;  state_in = ST_RP_MUL;
            end else begin
               w_in = wn;  state_in = ST_TK_SMUL;
            end
         end
         ST_RP_MUL: begin
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_RP_DIV;
            go_x = 64'(spd_ff[w_ff]);  go_y = 64'(gain_ff);
         end
         ST_RP_DIV: begin
            // divide by 65536000: drop 16 bits, clamp, then reciprocal of 1000
            rp_t = (eng_c_ff + RPM_ROUND) >> 16;
            go = 1'b1;  go_op = EOP_MUL;  go_ret = ST_RP_OUT;
            go_x = (rp_t > RPM_T_SAT) ? RPM_T_SAT : rp_t;  go_y = RPM_RECIP;
         end
         ST_RP_OUT: begin
            rp_t  = eng_c_ff >> 32;
            rpm_v = (rp_t > RPM_LIMIT) ? 13'(RPM_LIMIT) : rp_t[12:0];
            rsp_rpm_in   = signs_ff[w_ff] ? -$signed(rpm_v) : $signed(rpm_v);
            rsp_steer_in = 17'(head_ff[w_ff]) + 17'(off_ff[w_ff]);
            rsp_wheel_in = w_ff;
            rsp_last_in  = (w_ff == WHEEL_BRIGHT);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (w_ff == WHEEL_BRIGHT) begin
                  w_in = '0;  state_in = ST_IDLE;
               end else begin
                  w_in = wn;  state_in = ST_RP_MUL;
               end
            end
         end
      endcase

      if (go) begin
         state_in  = ST_ENG;
         ret_in    = go_ret;
         eng_op_in = go_op;
         unique case (go_op)
            EOP_MUL: begin
               eng_a_in = go_x;  eng_b_in = go_y;  eng_c_in = '0;  eng_cnt_in = 7'd32;
            end
            EOP_DIV: begin
               eng_a_in = '0;  eng_b_in = go_x;  eng_c_in = go_y;  eng_cnt_in = 7'd64;
            end
            EOP_SQRT: begin
               eng_a_in = go_x;  eng_b_in = '0;  eng_c_in = '0;  eng_cnt_in = 7'd32;
            end
            EOP_CORDIC: begin
               eng_cnt_in = 7'(CORDIC_STEPS);
               priority if ($signed(go_x) < 0 && $signed(go_y) >= 0) begin
                  eng_a_in = go_y;  eng_b_in = 64'(-$signed(go_x));
                  eng_c_in = 64'(QUARTER_TURN);
               end else if ($signed(go_x) < 0) begin
                  eng_a_in = 64'(-$signed(go_y));  eng_b_in = go_x;
                  eng_c_in = 64'(-QUARTER_TURN);
               end else begin
                  eng_a_in = go_x;  eng_b_in = go_y;  eng_c_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         w_ff         <= '0;
         k_ff         <= 1'b0;
         radius_ff    <= RADIUS_RST;
         slim_ff      <= SPEED_LIMIT_RST;
         tlim_ff      <= TURN_LIMIT_RST;
         gain_ff      <= DRIVE_GAIN_RST;
         off_ff       <= '{default: '0};
         signs_ff     <= '0;
         hvx_ff       <= '0;
         hvy_ff       <= '0;
         htn_ff       <= '0;
         idle_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         w_ff         <= w_in;
         k_ff         <= k_in;
         radius_ff    <= radius_in;
         slim_ff      <= slim_in;
         tlim_ff      <= tlim_in;
         gain_ff      <= gain_in;
         off_ff       <= off_in;
         signs_ff     <= signs_in;
         hvx_ff       <= hvx_in;
         hvy_ff       <= hvy_in;
         htn_ff       <= htn_in;
         idle_ff      <= idle_in;
      end
      eng_op_ff    <= eng_op_in;
      eng_cnt_ff   <= eng_cnt_in;
      eng_a_ff     <= eng_a_in;
      eng_b_ff     <= eng_b_in;
      eng_c_ff     <= eng_c_in;
      cv_ff        <= cv_in;
      cwz_ff       <= cwz_in;
      tmp_ff       <= tmp_in;
      den_ff       <= den_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      thf_ff       <= thf_in;
      tbx_ff       <= tbx_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      spd_ff       <= spd_in;
      head_ff      <= head_in;
      rsp_wheel_ff <= rsp_wheel_in;
      rsp_steer_ff <= rsp_steer_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

[hdl/tws_checker.sv]
// port-level assertions for the swerve kinematics block and their bind
module tws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tws_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // steer_target, drive_rpm, zero pad
   input logic [tws_pkg::WHEEL_W-1:0]       rsp_tuser,  // wheel
   input logic                              rsp_tlast   // last_wheel
);
   import tws_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_last_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == WHEEL_BRIGHT)))
      else $error("tlast not on back-right wheel");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting a transaction");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_rpm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[29:17]) <= 13'sd3500 &&
                      $signed(rsp_tdata[29:17]) >= -13'sd3500 && rsp_tdata[31:30] == 2'b00))
      else $error("drive rpm out of range");

endmodule

bind three_wheel_swerve_kinematics tws_checker u_tws_checker (.*);

[test/three_wheel_swerve_kinematics_tb.sv]
// testbench for the three-wheel swerve kinematics block: random and directed commands and ticks checked against a predictor
module three_wheel_swerve_kinematics_tb;
   import tws_pkg::*;

   typedef struct packed {
      logic               op;
      logic signed [15:0] lin_x;
      logic signed [15:0] lin_y;
      logic signed [15:0] turn_rate;
   } req_item_type;

   typedef struct packed {
      logic [WHEEL_W-1:0]        wheel;
      logic signed [STEER_W-1:0] steer;
      logic signed [RPM_W-1:0]   rpm;
      logic                      last;
   } wheel_target_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [WHEEL_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   three_wheel_swerve_kinematics uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint radius, spd_lim, trn_lim, gain;
   longint offs[3];
   logic [2:0] signs;
   longint hold_vx, hold_vy, hold_wz;
   longint idle_cnt;

   req_item_type     pending_items[$];
   wheel_target_type expected_targets[$];
   int  errors = 0;
   bit  quiet_phase = 1'b0;
   bit  hold_sender = 1'b0;

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_root(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else r = r >>> 1;
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint heading(longint x, longint y);
      longint z, t, dx, dy, h;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         dx = shr(y, i);
         dy = shr(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
         end
      end
      h = shr(z + 128, 8);
      if (h > 18000) h -= 36000;
      if (h <= -18000) h += 36000;
      return h;
   endfunction

   function automatic longint limit_component(longint v, longint lim, longint s);
      longint q;
      q = ((v < 0 ? -v : v) * lim + s / 2) / s;
      return v < 0 ? -q : q;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_RADIUS:      radius  = d[11:0];
         REG_SPEED_LIMIT: spd_lim = d[14:0];
         REG_TURN_LIMIT:  trn_lim = d[14:0];
         REG_DRIVE_GAIN:  gain    = d;
         REG_OFF_FRONT:   offs[0] = longint'($signed(d[15:0]));
         REG_OFF_BLEFT:   offs[1] = longint'($signed(d[15:0]));
         REG_OFF_BRIGHT:  offs[2] = longint'($signed(d[15:0]));
         REG_DRIVE_SIGNS: signs   = d[2:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_wheels(req_item_type it);
      longint vx, vy, wz, s, a, b, hf, bx, by, maxs, lim1000, r, rpm;
      longint cx[3], cy[3], sp[3], hd[3];
      wheel_target_type w;
      if (it.op == OP_COMMAND) begin
         vx = it.lin_x; vy = it.lin_y; wz = it.turn_rate;
         if (vx * vx + vy * vy > spd_lim * spd_lim) begin
            s = int_root(vx * vx + vy * vy);
            vx = limit_component(vx, spd_lim, s);
            vy = limit_component(vy, spd_lim, s);
         end
         if (wz > trn_lim) wz = trn_lim;
         if (wz < -trn_lim) wz = -trn_lim;
         hold_vx = vx; hold_vy = vy; hold_wz = wz;
         idle_cnt = 0;
         return;
      end
      if (idle_cnt < 65535) idle_cnt++;
      if (idle_cnt > TIMEOUT_TICKS_DEF) begin
         hold_vx = 0; hold_vy = 0; hold_wz = 0;
      end
      maxs = 0;
      if (hold_vx > 10 || hold_vx < -10 || hold_vy > 10 || hold_vy < -10 ||
          hold_wz > 10 || hold_wz < -10) begin
         a = hold_wz * radius;
         b = shr(a * 56756 + 32768, 16);
         hf = shr(a + 1, 1);
         bx = hold_vx * 1000; by = hold_vy * 1000;
         cx[0] = bx;     cy[0] = by + a;
         cx[1] = bx - b; cy[1] = by - hf;
         cx[2] = bx + b; cy[2] = by - hf;
         for (int i = 0; i < 3; i++) begin
            sp[i] = int_root(cx[i] * cx[i] + cy[i] * cy[i]);
            hd[i] = heading(cx[i], cy[i]);
            if (sp[i] > maxs) maxs = sp[i];
         end
         lim1000 = spd_lim * 1000;
         if (maxs > lim1000)
            for (int i = 0; i < 3; i++) sp[i] = (sp[i] * lim1000 + maxs / 2) / maxs;
      end else begin
         for (int i = 0; i < 3; i++) begin
            sp[i] = 0; hd[i] = 0;
         end
      end
      for (int i = 0; i < 3; i++) begin
         r = (sp[i] * gain + 32768000) / 65536000;
         rpm = r > 3500 ? 3500 : r;
         if (signs[i]) rpm = -rpm;
         w.wheel = WHEEL_W'(i);
         w.steer = STEER_W'(hd[i] + offs[i]);
         w.rpm   = RPM_W'(rpm);
         w.last  = (WHEEL_W'(i) == WHEEL_BRIGHT);
         expected_targets.push_back(w);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_wheels(req_item_type'({req_tuser, req_tdata[15:0], req_tdata[31:16],
                                           req_tdata[47:32]}));
            void'(pending_items.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > (req_tvalid && req_tready ? 0 : 0) && !hold_sender
                && (quiet_phase || $urandom_range(99) >= 30)) begin
               req_tvalid <= (pending_items.size() > 0);
               if (pending_items.size() > 0) begin
                  req_tuser <= pending_items[0].op;
                  req_tdata <= {pending_items[0].turn_rate, pending_items[0].lin_y,
                                pending_items[0].lin_x};
               end
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      wheel_target_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_targets.size() == 0) begin
               $error("unexpected transaction wheel=%0d", rsp_tuser);
               errors++;
            end else begin
               e = expected_targets.pop_front();
               if (rsp_tuser !== e.wheel) begin
                  $error("wheel exp %0d got %0d", e.wheel, rsp_tuser); errors++;
               end
               if (rsp_tdata[16:0] !== e.steer) begin
                  $error("steer_target exp %0d got %0d", e.steer, $signed(rsp_tdata[16:0]));
                  errors++;
               end
               if (rsp_tdata[29:17] !== e.rpm) begin
                  $error("drive_rpm exp %0d got %0d", e.rpm, $signed(rsp_tdata[29:17]));
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_wheel exp %0d got %0d", e.last, rsp_tlast); errors++;
               end
            end
         end
         rsp_tready <= quiet_phase || ($urandom_range(99) >= 30);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      write_register(idx, d);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_tvalid || expected_targets.size() > 0)
         @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   function automatic void add_item(logic op, int x, int y, int w);
      req_item_type it;
      it.op = op; it.lin_x = 16'(x); it.lin_y = 16'(y); it.turn_rate = 16'(w);
      pending_items.push_back(it);
   endfunction

   function automatic void add_random(int n);
      int v;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 35) begin
            v = $urandom_range(3);
            if (v == 0) add_item(OP_COMMAND, $urandom, $urandom, $urandom);
            else if (v == 1)
               add_item(OP_COMMAND, $urandom_range(40) - 20, $urandom_range(40) - 20,
                        $urandom_range(40) - 20);
            else add_item(OP_COMMAND, $urandom_range(8000) - 4000,
                          $urandom_range(8000) - 4000, $urandom_range(8000) - 4000);
         end else add_item(OP_TICK, $urandom, $urandom, $urandom);
      end
   endfunction

   initial begin
      write_register(REG_RADIUS, 20'd250);
      write_register(REG_SPEED_LIMIT, 20'd3000);
      write_register(REG_TURN_LIMIT, 20'd3000);
      write_register(REG_DRIVE_GAIN, 20'd79272);
      for (int i = 0; i < 3; i++) offs[i] = 0;
      signs = 3'd0;
      hold_vx = 0; hold_vy = 0; hold_wz = 0; idle_cnt = 0;
      hold_sender = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, 32767, 32767, 32767);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, -32768, -32768, -32768);
      add_item(OP_TICK, -1, -1, -1);
      add_item(OP_COMMAND, 10, -10, 10);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, 11, 0, 0);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, -500, 0, 0);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, 0, -500, 0);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, 0, 0, 400);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_COMMAND, 1000, 700, 0);
      for (int i = 0; i < 52; i++) add_item(OP_TICK, 0, 0, 0);
      hold_sender = 1'b0;
      drain();
      // extremes of configuration
      hold_sender = 1'b1;
      csr_write(REG_RADIUS, 20'd4095);
      csr_write(REG_SPEED_LIMIT, 20'd32767);
      csr_write(REG_TURN_LIMIT, 20'd32767);
      csr_write(REG_DRIVE_GAIN, 20'hFFFFF);
      csr_write(REG_OFF_FRONT, 20'(18000));
      csr_write(REG_OFF_BLEFT, 20'(16'(-18000)));
      csr_write(REG_OFF_BRIGHT, 20'(16'(-1)));
      csr_write(REG_DRIVE_SIGNS, 20'd7);
      add_item(OP_COMMAND, -32768, 32767, -32768);
      add_item(OP_TICK, 0, 0, 0);
      add_random(130);
      hold_sender = 1'b0;
      drain();
      hold_sender = 1'b1;
      csr_write(REG_RADIUS, 20'd0);
      csr_write(REG_SPEED_LIMIT, 20'd0);
      csr_write(REG_TURN_LIMIT, 20'd0);
      csr_write(REG_DRIVE_GAIN, 20'd0);
      csr_write(REG_DRIVE_SIGNS, 20'd2);
      add_random(40);
      hold_sender = 1'b0;
      drain();
      hold_sender = 1'b1;
      csr_write(REG_RADIUS, 20'($urandom_range(4095)));
      csr_write(REG_SPEED_LIMIT, 20'($urandom_range(6000)));
      csr_write(REG_TURN_LIMIT, 20'($urandom_range(6000)));
      csr_write(REG_DRIVE_GAIN, 20'd79272);
      csr_write(REG_OFF_FRONT, 20'(16'(-9000)));
      csr_write(REG_OFF_BLEFT, 20'(12000));
      csr_write(REG_OFF_BRIGHT, 20'(16'(-18000)));
      csr_write(REG_DRIVE_SIGNS, 20'd5);
      quiet_phase = 1'b1;
      add_random(80);
      hold_sender = 1'b0;
      drain();
      quiet_phase = 1'b0;
      add_random(100);
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
